// File: sv/fsg_pkg.sv
`timescale 1ns / 1ps

package fsg_pkg;

    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;
    localparam int PLANE_COUNT = 16;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int COL_W      = $clog2(GRID_WIDTH);
    localparam int ROW_W      = $clog2(GRID_HEIGHT);
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_STAMP = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    typedef logic [PLANE_COUNT-1:0] word_t;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] plane;
        logic [8:0] col;
        logic [8:0] row;
        logic [3:0] disc_radius;
    } cmd_t;

    typedef struct packed {
        logic        plane_bit;
        logic [15:0] cell_planes;
        logic        done_res;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        word_t             wdata;
    } mem_req_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(c);
    endfunction

endpackage

// File: sv/fsg_if.sv
`timescale 1ns / 1ps

interface fsg_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] plane;
    logic [8:0] col;
    logic [8:0] row;
    logic [3:0] disc_radius;

    modport source (output valid, action, plane, col, row, disc_radius, input ready);
    modport sink   (input valid, action, plane, col, row, disc_radius, output ready);
endinterface

interface fsg_res_if;
    logic        valid;
    logic        ready;
    logic        plane_bit;
    logic [15:0] cell_planes;
    logic        done_res;

    modport source (output valid, plane_bit, cell_planes, done_res, input ready);
    modport sink   (input valid, plane_bit, cell_planes, done_res, output ready);
endinterface

// File: sv/fsg_ram.sv
`timescale 1ns / 1ps

module fsg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: sv/fsg_ctrl.sv
`timescale 1ns / 1ps

module fsg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  fsg_pkg::cmd_t    cmd,
    output logic             cmd_ready,
    output logic             res_valid,
    output fsg_pkg::res_t    res,
    input  logic             res_ready,
    output fsg_pkg::mem_req_t mem_req,
    input  fsg_pkg::word_t   mem_rdata
);
    import fsg_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_TRD   = 4'd2;
    localparam logic [3:0] S_TWR   = 4'd3;
    localparam logic [3:0] S_SSCAN = 4'd4;
    localparam logic [3:0] S_SWR   = 4'd5;
    localparam logic [3:0] S_RDI   = 4'd6;
    localparam logic [3:0] S_RDC   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic              boot_reg, boot_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [COL_W-1:0]  x_reg, x_next;
    logic [ROW_W-1:0]  y_reg, y_next;
    logic [2:0]        step_reg, step_next;
    word_t             nbr_reg [4];
    word_t             nbr_next [4];
    logic signed [4:0] dx_reg, dx_next, dy_reg, dy_next;
    cmd_t              cmd_reg, cmd_next;
    logic              pbit_reg, pbit_next;
    logic [15:0]       cells_reg, cells_next;

    logic [COL_W-1:0]  xl, xr;
    logic [ADDR_W-1:0] nbr_addr;
    word_t             c0, c1, c2, b1, l1, r1, mv0, mv1, mv2;
    logic signed [9:0] nx, ny;
    logic [9:0]        dx2, dy2;
    logic [10:0]       dist2;
    logic [7:0]        rad2;
    logic              hit, last_pos;
    logic signed [4:0] rad_s;
    word_t             plane_one, rd_shift;

    assign xl = (x_reg == '0) ? COL_W'(GRID_WIDTH - 1) : x_reg - 1'b1;
    assign xr = (x_reg == COL_W'(GRID_WIDTH - 1)) ? '0 : x_reg + 1'b1;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    nbr_addr = cell_addr(y_reg, x_reg);
            2'd1:    nbr_addr = cell_addr(y_reg + 1'b1, x_reg);
            2'd2:    nbr_addr = cell_addr(y_reg + 1'b1, xl);
            default: nbr_addr = cell_addr(y_reg + 1'b1, xr);
        endcase
    end

    // Move rule: below first, then down-left, then down-right.
    assign mv0 = nbr_reg[0] & ~nbr_reg[1];
    assign b1  = nbr_reg[1] | mv0;
    assign c0  = nbr_reg[0] & ~mv0;
    assign mv1 = c0 & ~nbr_reg[2];
    assign l1  = nbr_reg[2] | mv1;
    assign c1  = c0 & ~mv1;
    assign mv2 = c1 & ~mem_rdata;
    assign r1  = mem_rdata | mv2;
    assign c2  = c1 & ~mv2;

    assign rad_s = $signed({1'b0, cmd_reg.disc_radius});
    assign nx    = $signed({2'b00, cmd_reg.col[8:1]}) + 10'(dx_reg);
    assign ny    = $signed({2'b00, cmd_reg.row[8:1]}) + 10'(dy_reg);
    assign dx2   = 10'(10'(dx_reg) * 10'(dx_reg));
    assign dy2   = 10'(10'(dy_reg) * 10'(dy_reg));
    assign dist2 = 11'(dx2) + 11'(dy2);
    assign rad2  = 8'(cmd_reg.disc_radius) * 8'(cmd_reg.disc_radius);
    assign hit   = !nx[9] && !ny[9] && (int'(nx) < GRID_WIDTH)
                   && (int'(ny) < GRID_HEIGHT) && (dist2 <= 11'(rad2))
                   && (int'(cmd_reg.plane) < PLANE_COUNT);
    assign last_pos  = (dx_reg == rad_s) && (dy_reg == rad_s);
    assign plane_one = word_t'(1) << cmd_reg.plane;
    assign rd_shift  = mem_rdata >> cmd_reg.plane;

    always_comb
    begin
        state_next = state_reg;
        boot_next  = boot_reg;
        ptr_next   = ptr_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        step_next  = step_reg;
        nbr_next   = nbr_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        cmd_next   = cmd_reg;
        pbit_next  = pbit_reg;
        cells_next = cells_reg;
        mem_req    = '{we: 1'b0, addr: ptr_reg, wdata: '0};
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.we = 1'b1;
                ptr_next   = ptr_reg + 1'b1;
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = boot_reg ? S_IDLE : S_FIN;
                    boot_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    pbit_next  = 1'b0;
                    cells_next = '0;
                    step_next  = '0;
                    ptr_next   = '0;
                    x_next     = '0;
                    y_next     = ROW_W'(GRID_HEIGHT - 2);
                    dx_next    = -$signed({1'b0, cmd.disc_radius});
                    dy_next    = -$signed({1'b0, cmd.disc_radius});
                    case (cmd.action)
                        ACT_TICK:  state_next = S_TRD;
                        ACT_STAMP: state_next = S_SSCAN;
                        ACT_READ:
                        begin
                            if (int'(cmd.col) < GRID_WIDTH && int'(cmd.row) < GRID_HEIGHT)
                            begin
                                state_next = S_RDI;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        default:   state_next = S_CLEAR;
                    endcase
                end
            end
            S_TRD:
            begin
                mem_req.addr = nbr_addr;
                if (step_reg != 3'd0 && step_reg != 3'd4)
                begin
                    nbr_next[step_reg[1:0] - 2'd1] = mem_rdata;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd4)
                begin
                    nbr_next[0] = c2;
                    nbr_next[1] = b1;
                    nbr_next[2] = l1;
                    nbr_next[3] = r1;
                    step_next   = '0;
                    state_next  = S_TWR;
                end
            end
            S_TWR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = nbr_addr;
                mem_req.wdata = nbr_reg[step_reg[1:0]];
                step_next     = step_reg + 1'b1;
                if (step_reg == 3'd3)
                begin
                    step_next  = '0;
                    state_next = S_TRD;
                    if (x_reg == COL_W'(GRID_WIDTH - 1))
                    begin
                        x_next = '0;
                        y_next = y_reg - 1'b1;
                        if (y_reg == '0)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
            end
            S_SSCAN:
            begin
                mem_req.addr = cell_addr(ROW_W'(ny), COL_W'(nx));
                ptr_next     = mem_req.addr;
                if (hit)
                begin
                    state_next = S_SWR;
                end
                else
                begin
                    if (dx_reg == rad_s)
                    begin
                        dx_next = -rad_s;
                        dy_next = dy_reg + 1'b1;
                    end
                    else
                    begin
                        dx_next = dx_reg + 1'b1;
                    end
                    if (last_pos)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SWR:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = mem_rdata | plane_one;
                state_next    = last_pos ? S_FIN : S_SSCAN;
                if (dx_reg == rad_s)
                begin
                    dx_next = -rad_s;
                    dy_next = dy_reg + 1'b1;
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            S_RDI:
            begin
                mem_req.addr = cell_addr(ROW_W'(cmd_reg.row), COL_W'(cmd_reg.col));
                state_next   = S_RDC;
            end
            S_RDC:
            begin
                cells_next = 16'(mem_rdata);
                pbit_next  = (int'(cmd_reg.plane) < PLANE_COUNT) ? rd_shift[0] : 1'b0;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = '{plane_bit: pbit_reg, cell_planes: cells_reg, done_res: 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            boot_reg  <= 1'b1;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        step_reg  <= step_next;
        nbr_reg   <= nbr_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        cmd_reg   <= cmd_next;
        pbit_reg  <= pbit_next;
        cells_reg <= cells_next;
    end

endmodule

// File: sv/falling_sand_grid_update_core.sv
`timescale 1ns / 1ps

// Falling-sand grid engine: the grid lives in one single-port synchronous RAM of
// GRID_WIDTH x GRID_HEIGHT words, one bit per sand plane, and a sequencer works one
// command at a time through that single RAM port. A tick visits every cell from the
// second-last row up, reading the cell and its three lower neighbors and then writing
// all four back. A stamp walks the (2r+1)^2 square around the center (col/2, row/2),
// with one extra write step for each cell that is set. A read of a cell outside the
// grid skips the RAM access, and a clear zeroes every cell in turn. After reset the
// block sweeps the RAM to zero and holds cmd.ready low until that is done. Each
// command yields exactly one result transfer; the result sits in an output register,
// so the next command can be taken while the previous result waits.

module falling_sand_grid_update_core (
    input logic        clk,
    input logic        rst_n,
    fsg_cmd_if.sink    cmd,
    fsg_res_if.source  res
);
    import fsg_pkg::*;

    cmd_t     cmd_word;
    res_t     res_word;
    res_t     out_reg;
    logic     out_valid_reg;
    logic     res_valid;
    logic     res_ready;
    mem_req_t mem_req;
    word_t    mem_rdata;

    assign cmd_word = '{action: cmd.action, plane: cmd.plane, col: cmd.col,
                        row: cmd.row, disc_radius: cmd.disc_radius};

    // The sequencer may hand over a result whenever the output register is empty
    // or is being emptied in this cycle.
    assign res_ready = !out_valid_reg || res.ready;

    fsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd       (cmd_word),
        .cmd_ready (cmd.ready),
        .res_valid (res_valid),
        .res       (res_word),
        .res_ready (res_ready),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    fsg_ram #(
        .WIDTH (PLANE_COUNT),
        .DEPTH (CELL_COUNT)
    ) u_grid (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res_word;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.plane_bit   = out_reg.plane_bit;
    assign res.cell_planes = out_reg.cell_planes;
    assign res.done_res    = out_reg.done_res;

endmodule
